// File: hdl/pty_line_discipline_assert.svh
// ----------------------------------------------------------------------------
// pty line discipline assertion macros
// concurrent checks clocked on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef PTY_LINE_DISCIPLINE_ASSERT_SVH
`define PTY_LINE_DISCIPLINE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define PLD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pty line discipline check failed");

// next-cycle implication
`define PLD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pty line discipline check failed");

`else

`define PLD_ASSERT_IMP(name, ante, cons)
`define PLD_ASSERT_NXT(name, ante, cons)

`endif

`endif

// File: hdl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg
// shared types and character constants of the pty line discipline
// ----------------------------------------------------------------------------
package pld_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int FILL_W      = 11;

    // request actions
    typedef enum logic [1:0] {
        ACT_MASTER_WRITE = 2'd0,
        ACT_SLAVE_READ   = 2'd1,
        ACT_SLAVE_WRITE  = 2'd2,
        ACT_MASTER_READ  = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_EOF     = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    // raised signal codes
    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_INTR = 2'd1,
        SIG_SUSP = 2'd2,
        SIG_QUIT = 2'd3
    } t_signal;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ISIG   = 2'd0,
        CFG_ICANON = 2'd1,
        CFG_ECHO   = 2'd2
    } t_cfg_reg;

    // classified request kinds
    typedef enum logic [2:0] {
        K_SIGNAL = 3'd0,
        K_EOF    = 3'd1,
        K_QUEUE  = 3'd2,
        K_SREAD  = 3'd3,
        K_SWRITE = 3'd4,
        K_MREAD  = 3'd5
    } t_kind;

    // back sequencer states
    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_RUN  = 2'd1,
        B_DONE = 2'd2
    } t_bstate;

    // characters
    localparam logic [7:0] CH_INTR     = 8'd3;
    localparam logic [7:0] CH_EOF      = 8'd4;
    localparam logic [7:0] CH_SUSP     = 8'd26;
    localparam logic [7:0] CH_QUIT     = 8'd28;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CTRL_OFFSET = 8'h40;

    // classified request from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        t_signal    sig;
        logic       echo;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [FILL_W-1:0] tm_fill;
        logic [FILL_W-1:0] ts_fill;
        t_signal           sig;
        t_status           status;
        logic [7:0]        read_byte;
    } t_result;

endpackage

// File: hdl/pld_front.sv
// ----------------------------------------------------------------------------
// pld_front
// holds the mode bits and classifies each incoming request
// ----------------------------------------------------------------------------
module pld_front
    import pld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic                  i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_data,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    input  logic                  i_q_ready
);

    logic    r_isig, r_icanon, r_echo;
    t_action act;
    logic [7:0] ch;
    t_signal sig;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = i_q_ready;
    assign o_push      = i_valid && i_q_ready;

    // mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isig   <= 1'b1;
            r_icanon <= 1'b1;
            r_echo   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ISIG:   r_isig   <= i_cfg_data;
                CFG_ICANON: r_icanon <= i_cfg_data;
                CFG_ECHO:   r_echo   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control character detection
    always_comb begin
        act = t_action'(i_data[1:0]);
        ch  = i_data[9:2];
        sig = SIG_NONE;
        if (r_isig) begin
            case (ch)
                CH_INTR: sig = SIG_INTR;
                CH_SUSP: sig = SIG_SUSP;
                CH_QUIT: sig = SIG_QUIT;
                default: sig = SIG_NONE;
            endcase
        end
    end

    // request classification
    always_comb begin
        o_cmd.data = ch;
        o_cmd.echo = r_echo;
        o_cmd.sig  = SIG_NONE;
        case (act)
            ACT_MASTER_WRITE: begin
                if (sig != SIG_NONE) begin
                    o_cmd.kind = K_SIGNAL;
                    o_cmd.sig  = sig;
                end else if (ch == CH_EOF && r_icanon) begin
                    o_cmd.kind = K_EOF;
                end else begin
                    o_cmd.kind = K_QUEUE;
                end
            end
            ACT_SLAVE_READ:  o_cmd.kind = K_SREAD;
            ACT_SLAVE_WRITE: o_cmd.kind = K_SWRITE;
            ACT_MASTER_READ: o_cmd.kind = K_MREAD;
            default:         o_cmd.kind = K_MREAD;
        endcase
    end

endmodule

// File: hdl/pld_queue.sv
// ----------------------------------------------------------------------------
// pld_queue
// two-entry request queue between the front and the back sequencer
// ----------------------------------------------------------------------------
module pld_queue
    import pld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_ent [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[r_rd];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr] <= i_cmd;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/pld_back.sv
// ----------------------------------------------------------------------------
// pld_back
// byte fifos and the sequencer that carries out one request at a time
// ----------------------------------------------------------------------------
`include "pty_line_discipline_assert.svh"

module pld_back
    import pld_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_res
);

    localparam int PW = $clog2(2 * FIFO_DEPTH);
    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [PW-1:0] DEPTH_P   = PW'(FIFO_DEPTH);
    localparam logic [PW-1:0] LAST_POS  = PW'(2 * FIFO_DEPTH - 1);
    localparam logic [PW:0]   TWO_DEPTH = (PW + 1)'(2 * FIFO_DEPTH);

    // positions run modulo twice the depth
    function automatic logic [PW-1:0] f_fill(input logic [PW-1:0] h, input logic [PW-1:0] t);
        logic [PW:0] d;
        d = (h >= t) ? ({1'b0, h} - {1'b0, t}) : ({1'b0, h} + TWO_DEPTH - {1'b0, t});
        return d[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_slot(input logic [PW-1:0] pos);
        logic [PW-1:0] s;
        s = (pos >= DEPTH_P) ? (pos - DEPTH_P) : pos;
        return s[AW-1:0];
    endfunction

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] pos);
        return (pos == LAST_POS) ? '0 : (pos + PW'(1));
    endfunction

    logic [7:0]    ts_mem [FIFO_DEPTH];
    logic [7:0]    tm_mem [FIFO_DEPTH];

    t_bstate       r_state, n_state;
    t_cmd          r_cmd;
    logic [1:0]    r_step;
    logic          r_drop;
    t_status       r_status;
    logic          r_rd_hit, r_rd_tm;
    logic [PW-1:0] r_ts_head, r_ts_tail, r_tm_head, r_tm_tail;
    logic          r_eof;
    logic [7:0]    r_ts_rdata, r_tm_rdata;
    logic          r_out_valid;
    t_result       r_out;

    logic [PW-1:0] ts_fill, tm_fill;
    logic          ts_full, tm_full, ts_empty, tm_empty;
    logic          ts_push, tm_push, ts_pop, tm_pop, ts_flush;
    logic [7:0]    tm_byte;
    logic          set_eof, clr_eof, last_step, out_free, load;
    t_status       run_status;

    assign ts_fill  = f_fill(r_ts_head, r_ts_tail);
    assign tm_fill  = f_fill(r_tm_head, r_tm_tail);
    assign ts_full  = (ts_fill >= DEPTH_P);
    assign tm_full  = (tm_fill >= DEPTH_P);
    assign ts_empty = (ts_fill == '0);
    assign tm_empty = (tm_fill == '0);
    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (i_q_valid) n_state = B_RUN;
            B_RUN:  if (last_step) n_state = B_DONE;
            B_DONE: if (out_free)  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // per-state actions
    always_comb begin
        o_q_pop    = 1'b0;
        load       = 1'b0;
        ts_push    = 1'b0;
        tm_push    = 1'b0;
        ts_pop     = 1'b0;
        tm_pop     = 1'b0;
        ts_flush   = 1'b0;
        set_eof    = 1'b0;
        clr_eof    = 1'b0;
        last_step  = 1'b0;
        tm_byte    = r_cmd.data;
        run_status = ST_OK;
        case (r_state)
            B_IDLE: o_q_pop = i_q_valid;
            B_RUN: begin
                case (r_cmd.kind)
                    K_SIGNAL: begin
                        ts_flush  = (r_step == 2'd0);
                        tm_push   = 1'b1;
                        last_step = (r_step == 2'd3);
                        case (r_step)
                            2'd0:    tm_byte = CH_CARET;
                            2'd1:    tm_byte = r_cmd.data + CTRL_OFFSET;
                            2'd2:    tm_byte = CH_CR;
                            default: tm_byte = CH_LF;
                        endcase
                    end
                    K_EOF: begin
                        set_eof   = 1'b1;
                        last_step = 1'b1;
                    end
                    K_QUEUE: begin
                        ts_push   = 1'b1;
                        tm_push   = r_cmd.echo;
                        last_step = 1'b1;
                    end
                    K_SWRITE: begin
                        tm_push   = 1'b1;
                        last_step = 1'b1;
                    end
                    K_SREAD: begin
                        ts_pop    = !ts_empty;
                        clr_eof   = 1'b1;
                        last_step = 1'b1;
                        if (ts_empty) begin
                            run_status = r_eof ? ST_EOF : ST_EMPTY;
                        end
                    end
                    K_MREAD: begin
                        tm_pop     = !tm_empty;
                        last_step  = 1'b1;
                        run_status = tm_empty ? ST_EMPTY : ST_OK;
                    end
                    default: last_step = 1'b1;
                endcase
            end
            B_DONE: load = out_free;
            default: ;
        endcase
    end

    // fifo memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (ts_push && !ts_full) begin
            ts_mem[f_slot(r_ts_head)] <= r_cmd.data;
        end
        if (ts_pop) begin
            r_ts_rdata <= ts_mem[f_slot(r_ts_tail)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tm_push && !tm_full) begin
            tm_mem[f_slot(r_tm_head)] <= tm_byte;
        end
        if (tm_pop) begin
            r_tm_rdata <= tm_mem[f_slot(r_tm_tail)];
        end
    end

    // sequencer and fifo pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_step    <= 2'd0;
            r_ts_head <= '0;
            r_ts_tail <= '0;
            r_tm_head <= '0;
            r_tm_tail <= '0;
            r_eof     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_RUN) begin
                r_step <= r_step + 2'd1;
            end else begin
                r_step <= 2'd0;
            end
            if (ts_flush) begin
                r_ts_head <= r_ts_tail;
            end else if (ts_push && !ts_full) begin
                r_ts_head <= f_next(r_ts_head);
            end
            if (ts_pop) begin
                r_ts_tail <= f_next(r_ts_tail);
            end
            if (tm_push && !tm_full) begin
                r_tm_head <= f_next(r_tm_head);
            end
            if (tm_pop) begin
                r_tm_tail <= f_next(r_tm_tail);
            end
            if (set_eof) begin
                r_eof <= 1'b1;
            end else if (clr_eof) begin
                r_eof <= 1'b0;
            end
        end
    end

    // per-request bookkeeping
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd    <= i_q_cmd;
            r_drop   <= 1'b0;
            r_status <= ST_OK;
            r_rd_hit <= 1'b0;
            r_rd_tm  <= 1'b0;
        end else if (r_state == B_RUN) begin
            r_drop <= r_drop | (ts_push && ts_full) | (tm_push && tm_full);
            if (r_cmd.kind == K_SREAD || r_cmd.kind == K_MREAD) begin
                r_status <= run_status;
                r_rd_hit <= ts_pop || tm_pop;
                r_rd_tm  <= tm_pop;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.read_byte <= r_rd_hit ? (r_rd_tm ? r_tm_rdata : r_ts_rdata) : 8'd0;
            r_out.status    <= r_drop ? ST_DROPPED : r_status;
            r_out.sig       <= r_cmd.sig;
            r_out.ts_fill   <= FILL_W'(ts_fill);
            r_out.tm_fill   <= FILL_W'(tm_fill);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    // checks
    `PLD_ASSERT_IMP(a_ts_fill_bound, 1'b1, ts_fill <= DEPTH_P)
    `PLD_ASSERT_IMP(a_tm_fill_bound, 1'b1, tm_fill <= DEPTH_P)
    `PLD_ASSERT_NXT(a_signal_len,
        r_state == B_RUN && r_cmd.kind == K_SIGNAL && r_step == 2'd3, r_state == B_DONE)
    `PLD_ASSERT_IMP(a_eof_result, r_out_valid && r_out.status == ST_EOF,
        r_out.read_byte == 8'd0 && r_out.ts_fill == '0)
    `PLD_ASSERT_IMP(a_sig_result, r_out_valid && r_out.sig != SIG_NONE,
        r_out.read_byte == 8'd0 && r_out.status != ST_EOF && r_out.status != ST_EMPTY)

endmodule

// File: hdl/pty_line_discipline.sv
// ----------------------------------------------------------------------------
// pty_line_discipline
// terminal line discipline between a to-slave and a to-master byte fifo
// ----------------------------------------------------------------------------
// sequence: a request is taken from the queue, carried out, and its result is
//   registered once the result register is free; a signal byte's four bytes go
//   one per cycle through the single write port of the to-master memory
// one request at a time: the next is taken only after the last result is loaded
// reset: synchronous active low; clears pointers, eof flag, queue and
//   sequencer and sets all three mode bits; fifo memories are not cleared
module pty_line_discipline
    import pld_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic                   i_cfg_data,
    // requests
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // action[1:0], data_byte[9:2], zero[15:10]
    // results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // read_byte[7:0], status[9:8],
                                                  // signal_code[11:10], to_slave_fill[22:12],
                                                  // to_master_fill[33:23], zero[39:34]
);

    logic    push, q_ready, q_valid, q_pop;
    t_cmd    f_cmd, q_cmd;
    t_result res;

    // request classification
    pld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .i_q_ready   (q_ready)
    );

    // decoupling queue
    pld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // fifos and sequencer
    pld_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_res       (res)
    );

    // result packing
    assign m_axis_tdata = {6'd0, res.tm_fill, res.ts_fill, res.sig, res.status, res.read_byte};

endmodule
